>>> rtl/core/ist_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ist_pkg
// Shared types and codes for the integer set table.
// ----------------------------------------------------------------------------
package ist_pkg;

    // Action codes. Code 3 is unused and behaves as a query.
    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK   = 2'd0;  // added / removed / present
    localparam logic [1:0] ST_NOT  = 2'd1;  // already present / absent
    localparam logic [1:0] ST_FULL = 2'd2;  // add to a full table

    localparam int KEY_W   = 32;
    localparam int ENTRY_W = KEY_W + 1;     // {valid, key}
    localparam int IN_W    = 40;            // action + key, padded to bytes
    localparam int OUT_W   = 8;             // status, padded to bytes

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_COMMIT,
        S_HOLD
    } state_t;

endpackage : ist_pkg
`default_nettype wire

>>> rtl/core/ist_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ist_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ist_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 128,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule : ist_ram
`default_nettype wire

>>> rtl/core/integer_set_table_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// integer_set_table_core
// Set of 32-bit keys with add, remove and membership query.
// ----------------------------------------------------------------------------
// Holds up to CAPACITY distinct 32-bit keys. Each input word carries an
// action (0 add, 1 remove, 2 or 3 query) and a key; each yields one output
// word with a status: add gives 0 added, 1 already present, 2 table full
// (nothing stored); remove gives 0 removed, 1 absent; query gives 0 present,
// 1 absent. An add fills the lowest-numbered free entry. Entries live in a
// single RAM word each ({valid, key}) and one item is handled at a time by
// scanning the RAM one entry per cycle through its single read port, then
// writing back at most one entry. After a word is accepted the block scans
// every entry (one read issued per cycle, its data checked in the next),
// then commits the result and loads it into the output register once that
// register is free; m_tvalid then rises. The RAM scan takes most of the
// time per word. A new word is accepted once the previous result is loaded
// into the output register, even while that result waits on m_tready, so
// no new word is taken before the last one is through. After reset the
// block runs a clearing pass over every RAM entry, with s_tready low.
// ----------------------------------------------------------------------------
module integer_set_table_core
    import ist_pkg::*;
#(
    parameter int CAPACITY = 128
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    // Input words
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [IN_W-1:0]  s_tdata,   // [1:0] action, [33:2] key, rest zero
    // Output words
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic      [OUT_W-1:0] m_tdata    // [1:0] status, rest zero
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);

    state_t state_reg, state_next;

    // Control registers
    logic [AW-1:0] clr_reg,        clr_next;
    logic [AW-1:0] issue_reg,      issue_next;
    logic          issue_done_reg, issue_done_next;
    logic          pend_reg,       pend_next;
    logic [AW-1:0] pend_idx_reg,   pend_idx_next;
    logic          hit_reg,        hit_next;
    logic          free_reg,       free_next;
    logic          out_valid_reg,  out_valid_next;

    // Payload registers
    logic [1:0]       act_reg,      act_next;
    logic [KEY_W-1:0] key_reg,      key_next;
    logic [AW-1:0]    hit_idx_reg,  hit_idx_next;
    logic [AW-1:0]    free_idx_reg, free_idx_next;
    logic [1:0]       status_reg,   status_next;
    logic [1:0]       out_stat_reg, out_stat_next;

    // RAM port signals
    logic               ram_wr_en;
    logic [AW-1:0]      ram_wr_addr;
    logic [ENTRY_W-1:0] ram_wr_data;
    logic               ram_rd_en;
    logic [ENTRY_W-1:0] ram_rd_data;

    logic accept;
    logic out_free;
    logic ent_valid;
    logic ent_match;

    assign accept    = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign ent_valid = ram_rd_data[KEY_W];
    assign ent_match = ent_valid && (ram_rd_data[KEY_W-1:0] == key_reg);

    ist_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (issue_reg),
        .rd_data (ram_rd_data)
    );

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // last entry's read data is being checked this cycle
                if (pend_reg && (pend_idx_reg == LAST))
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                state_next = S_HOLD;
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs of the sequencer: handshake and RAM controls
    // ------------------------------------------------------------------
    always_comb
    begin
        s_tready    = 1'b0;
        ram_rd_en   = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = clr_reg;
        ram_wr_data = '0;
        status_next = status_reg;
        case (state_reg)
            S_CLEAR:
            begin
                ram_wr_en = 1'b1;
            end
            S_IDLE:
            begin
                s_tready = 1'b1;
            end
            S_SCAN:
            begin
                ram_rd_en = !issue_done_reg;
            end
            S_COMMIT:
            begin
                case (act_reg)
                    ACT_ADD:
                    begin
                        if (hit_reg)
                        begin
                            status_next = ST_NOT;
                        end
                        else if (free_reg)
                        begin
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = free_idx_reg;
                            ram_wr_data = {1'b1, key_reg};
                            status_next = ST_OK;
                        end
                        else
                        begin
                            status_next = ST_FULL;
                        end
                    end
                    ACT_REMOVE:
                    begin
                        if (hit_reg)
                        begin
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = hit_idx_reg;
                            ram_wr_data = {1'b0, key_reg};
                            status_next = ST_OK;
                        end
                        else
                        begin
                            status_next = ST_NOT;
                        end
                    end
                    default:
                    begin
                        // query, and the unused code that acts as one
                        status_next = hit_reg ? ST_OK : ST_NOT;
                    end
                endcase
            end
            S_HOLD:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Scan bookkeeping: issue one read a cycle, check each read's data in the next cycle, not later
    // ------------------------------------------------------------------
    always_comb
    begin
        clr_next        = clr_reg;
        issue_next      = issue_reg;
        issue_done_next = issue_done_reg;
        pend_next       = 1'b0;
        pend_idx_next   = pend_idx_reg;
        hit_next        = hit_reg;
        free_next       = free_reg;
        hit_idx_next    = hit_idx_reg;
        free_idx_next   = free_idx_reg;
        act_next        = act_reg;
        key_next        = key_reg;

        if ((state_reg == S_CLEAR) && (clr_reg != LAST))
        begin
            clr_next = clr_reg + AW'(1);
        end

        if (accept)
        begin
            act_next        = s_tdata[1:0];
            key_next        = s_tdata[KEY_W+1:2];
            issue_next      = '0;
            issue_done_next = 1'b0;
            hit_next        = 1'b0;
            free_next       = 1'b0;
        end

        if (ram_rd_en)
        begin
            pend_next     = 1'b1;
            pend_idx_next = issue_reg;
            if (issue_reg == LAST)
            begin
                issue_done_next = 1'b1;
            end
            else
            begin
                issue_next = issue_reg + AW'(1);
            end
        end

        if (pend_reg)
        begin
            if (ent_match && !hit_reg)
            begin
                hit_next     = 1'b1;
                hit_idx_next = pend_idx_reg;
            end
            if (!ent_valid && !free_reg)
            begin
                free_next     = 1'b1;
                free_idx_next = pend_idx_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: loaded from HOLD when the slot is free
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_stat_next  = out_stat_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if ((state_reg == S_HOLD) && out_free)
        begin
            out_valid_next = 1'b1;
            out_stat_next  = status_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_W-2){1'b0}}, out_stat_reg};

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            issue_reg      <= '0;
            issue_done_reg <= 1'b1;
            pend_reg       <= 1'b0;
            pend_idx_reg   <= '0;
            hit_reg        <= 1'b0;
            free_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            issue_reg      <= issue_next;
            issue_done_reg <= issue_done_next;
            pend_reg       <= pend_next;
            pend_idx_reg   <= pend_idx_next;
            hit_reg        <= hit_next;
            free_reg       <= free_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        key_reg      <= key_next;
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
        status_reg   <= status_next;
        out_stat_reg <= out_stat_next;
    end

endmodule : integer_set_table_core
`default_nettype wire
